@@ rtl/core/tptc_pkg.sv @@
`default_nettype none
package tptc_pkg;

    // Field widths fixed by the command format
    localparam int unsigned ASID_W    = 10;
    localparam int unsigned VPN_W     = 20;
    localparam int unsigned WORD_W    = 32;
    localparam int unsigned TAG_W     = 16;
    localparam int unsigned TAG_PG_W  = 6;
    localparam int unsigned RTAG_W    = 4;
    localparam int unsigned OUT_IDX_W = 10;

    // Bit position of the residual tag field in the entry word
    localparam int unsigned RTAG_SHIFT = 0;

    // Request function codes
    typedef enum logic [1:0] {
        FUNC_INSERT     = 2'd0,
        FUNC_PURGE_PAGE = 2'd1,
        FUNC_PURGE_ALL  = 2'd2,
        FUNC_PURGE_ASID = 2'd3
    } t_func;

    // Downstream purge command codes
    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_PAGE = 2'd1;
    localparam logic [1:0] KIND_ALL  = 2'd2;
    localparam logic [1:0] KIND_ASID = 2'd3;

    typedef struct packed {
        t_func              func;
        logic [ASID_W-1:0]  asid;
        logic [VPN_W-1:0]   vpn;
        logic [WORD_W-1:0]  pte_word;
        logic               insert_target;
    } t_req;

    typedef struct packed {
        logic [OUT_IDX_W-1:0] set_index;
        logic                 way_used;
        logic                 wrote_entry;
        logic                 removed_entry;
        logic [WORD_W-1:0]    stored_word;
        logic [TAG_W-1:0]     tag_value;
        logic [1:0]           purge_kind;
        logic [ASID_W-1:0]    purge_asid;
        logic [VPN_W-1:0]     purge_vpn;
        logic                 target_out;
    } t_res;

    // Way decision handed from the selector to the write-back logic
    typedef struct packed {
        logic                 way;
        logic                 tag_we;
        logic                 wrote;
        logic                 removed;
        logic                 rot_toggle;
        logic [2*TAG_W-1:0]   tag_word;
    } t_dec;

endpackage
`default_nettype wire

@@ rtl/core/tptc_ram.sv @@
`default_nettype none
module tptc_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write one word, read one word with registered data
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

@@ rtl/core/tptc_way_sel.sv @@
`default_nettype none
module tptc_way_sel (
    input  wire tptc_pkg::t_func                 i_func,
    input  wire logic [tptc_pkg::TAG_W-1:0]      i_tag,
    input  wire logic [2*tptc_pkg::TAG_W-1:0]    i_tag_word,
    input  wire logic                            i_rotate,
    output tptc_pkg::t_dec                       o_dec
);
    import tptc_pkg::*;

    logic [TAG_W-1:0] tag0;
    logic [TAG_W-1:0] tag1;
    logic             hit0;
    logic             hit1;

    assign tag0 = i_tag_word[TAG_W-1:0];
    assign tag1 = i_tag_word[2*TAG_W-1:TAG_W];
    assign hit0 = (tag0 == i_tag);
    assign hit1 = (tag1 == i_tag);

    // Pick the way and build the modified tag word of the set
    always_comb begin
        o_dec = '0;
        o_dec.tag_word = i_tag_word;
        unique case (i_func)
            FUNC_INSERT: begin
                o_dec.wrote  = 1'b1;
                o_dec.tag_we = 1'b1;
                priority if (hit0) begin
                    o_dec.way = 1'b0;
                end else if (hit1) begin
                    o_dec.way = 1'b1;
                end else if (tag0 == '0) begin
                    o_dec.way = 1'b0;
                end else if (tag1 == '0) begin
                    o_dec.way = 1'b1;
                end else begin
                    o_dec.way        = ~i_rotate;
                    o_dec.rot_toggle = 1'b1;
                end
                if (o_dec.way) begin
                    o_dec.tag_word[2*TAG_W-1:TAG_W] = i_tag;
                end else begin
                    o_dec.tag_word[TAG_W-1:0] = i_tag;
                end
            end
            FUNC_PURGE_PAGE: begin
                priority if (hit0) begin
                    o_dec.way                 = 1'b0;
                    o_dec.removed             = 1'b1;
                    o_dec.tag_we              = 1'b1;
                    o_dec.tag_word[TAG_W-1:0] = '0;
                end else if (hit1) begin
                    o_dec.way                         = 1'b1;
                    o_dec.removed                     = 1'b1;
                    o_dec.tag_we                      = 1'b1;
                    o_dec.tag_word[2*TAG_W-1:TAG_W]   = '0;
                end else begin
                    o_dec.way = 1'b0;
                end
            end
            default: begin
                // Full purges are handled by the clearing sweep
                o_dec.way = 1'b0;
            end
        endcase
    end

endmodule
`default_nettype wire

@@ rtl/core/two_way_page_table_cache_unit.sv @@
`default_nettype none
// A result strobe is registered from the S_WRITE write-back state that follows
// an accepted start. A new lookup or insert is taken only once busy is low again;
// the tag memory read is followed by its write-back in the next cycle.
// Purge all and purge by asid: busy stays high after S_WRITE while a sweep
// clears every set. Reset: synchronous, active low; a tag clearing sweep over
// all sets follows with busy high. Results cannot be stalled by the receiver.
module two_way_page_table_cache_unit #(
    parameter int unsigned INDEX_BITS = 10
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire tptc_pkg::t_req                i_req,
    output logic                               o_done,
    output tptc_pkg::t_res                     o_res,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [tptc_pkg::RTAG_W-1:0]   i_cfg_data
);
    import tptc_pkg::*;

    localparam int unsigned SETS = 1 << INDEX_BITS;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_WRITE = 3'b010,
        S_CLEAR = 3'b100
    } t_state;

    t_state                  r_state, n_state;
    logic [INDEX_BITS-1:0]   r_clr_cnt, n_clr_cnt;
    logic                    r_rotate, n_rotate;
    logic [RTAG_W-1:0]       r_rmask;
    t_req                    r_req;
    logic [INDEX_BITS-1:0]   r_idx;
    logic [TAG_W-1:0]        r_tag;
    logic [WORD_W-1:0]       r_stored;
    logic                    r_done, n_done;
    t_res                    r_res, n_res;

    logic [INDEX_BITS-1:0]   h_asid_sh;
    logic [INDEX_BITS-1:0]   h_idx;
    logic [TAG_W-1:0]        h_tag;
    logic [RTAG_W-1:0]       h_rtag;
    logic [WORD_W-1:0]       h_stored;
    logic                    accept;

    logic [2*TAG_W-1:0]      tag_rdata;
    logic                    tag_we;
    logic [INDEX_BITS-1:0]   tag_waddr;
    logic [2*TAG_W-1:0]      tag_wdata;
    logic                    ent_we;
    logic [WORD_W-1:0]       ent_rdata;
    t_dec                    dec;

    assign accept      = start && !busy;
    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_done      = r_done;
    assign o_res       = r_res;

    // Hash the incoming request: set index, tag and merged entry word
    assign h_asid_sh = INDEX_BITS'(i_req.asid) << (INDEX_BITS - ASID_W);
    assign h_idx     = i_req.vpn[INDEX_BITS-1:0] ^ h_asid_sh;
    assign h_tag     = {TAG_PG_W'(i_req.vpn >> INDEX_BITS), i_req.asid};
    assign h_rtag    = RTAG_W'(i_req.vpn >> (INDEX_BITS + TAG_PG_W)) & r_rmask;
    assign h_stored  = (i_req.pte_word & ~(WORD_W'(4'hf) << RTAG_SHIFT))
                     | (WORD_W'(h_rtag) << RTAG_SHIFT);

    // Tag memory: both ways of a set in one word
    tptc_ram #(
        .WIDTH (2*TAG_W),
        .DEPTH (SETS)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (tag_we),
        .i_waddr (tag_waddr),
        .i_wdata (tag_wdata),
        .i_raddr (h_idx),
        .o_rdata (tag_rdata)
    );

    // Entry memory: page table words, addressed by set and way
    tptc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (2*SETS)
    ) u_ent_ram (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr ({r_idx, dec.way}),
        .i_wdata (r_stored),
        .i_raddr ({r_idx, dec.way}),
        .o_rdata (ent_rdata)
    );

    tptc_way_sel u_way_sel (
        .i_func     (r_req.func),
        .i_tag      (r_tag),
        .i_tag_word (tag_rdata),
        .i_rotate   (r_rotate),
        .o_dec      (dec)
    );

    // Steer the tag write port between write-back and the clearing sweep
    always_comb begin
        tag_we    = 1'b0;
        tag_waddr = r_idx;
        tag_wdata = dec.tag_word;
        ent_we    = 1'b0;
        if (r_state == S_CLEAR) begin
            tag_we    = 1'b1;
            tag_waddr = r_clr_cnt;
            tag_wdata = '0;
        end else if (r_state == S_WRITE) begin
            tag_we = dec.tag_we;
            ent_we = dec.wrote;
        end
    end

    // Sequence requests and build the result
    always_comb begin
        n_state   = r_state;
        n_clr_cnt = r_clr_cnt;
        n_rotate  = r_rotate;
        n_done    = 1'b0;
        n_res     = r_res;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                n_done = 1'b1;
                n_res  = '0;
                if (dec.rot_toggle) begin
                    n_rotate = ~r_rotate;
                end
                unique case (r_req.func)
                    FUNC_INSERT, FUNC_PURGE_PAGE: begin
                        n_res.set_index     = OUT_IDX_W'(r_idx);
                        n_res.way_used      = dec.way;
                        n_res.wrote_entry   = dec.wrote;
                        n_res.removed_entry = dec.removed;
                        n_res.tag_value     = r_tag;
                        n_res.purge_asid    = r_req.asid;
                        n_res.purge_vpn     = r_req.vpn;
                        if (r_req.func == FUNC_INSERT) begin
                            n_res.stored_word = r_stored;
                            n_res.target_out  = r_req.insert_target;
                            n_res.purge_kind  = KIND_NONE;
                        end else begin
                            n_res.purge_kind  = KIND_PAGE;
                        end
                        n_state = S_IDLE;
                    end
                    FUNC_PURGE_ALL: begin
                        n_res.purge_kind = KIND_ALL;
                        n_clr_cnt        = '0;
                        n_state          = S_CLEAR;
                    end
                    FUNC_PURGE_ASID: begin
                        n_res.purge_kind = KIND_ASID;
                        n_res.purge_asid = r_req.asid;
                        n_clr_cnt        = '0;
                        n_state          = S_CLEAR;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_CLEAR: begin
                n_clr_cnt = r_clr_cnt + 1'b1;
                if (r_clr_cnt == INDEX_BITS'(SETS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr_cnt <= '0;
            r_rotate  <= 1'b0;
            r_rmask   <= '0;
            r_done    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr_cnt <= n_clr_cnt;
            r_rotate  <= n_rotate;
            r_done    <= n_done;
            if (i_cfg_valid && o_cfg_ready) begin
                r_rmask <= i_cfg_data;
            end
        end
    end

    // Hold the request and the result payload
    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (accept) begin
            r_req    <= i_req;
            r_idx    <= h_idx;
            r_tag    <= h_tag;
            r_stored <= h_stored;
        end
    end

`ifndef NO_ASSERTIONS
    a_done_after_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_state == S_WRITE))
        else $error("result strobe without a write-back cycle");

    a_accept_to_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_WRITE))
        else $error("accepted request did not enter write-back");

    a_removed_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_res.removed_entry) |-> (o_res.purge_kind == KIND_PAGE))
        else $error("entry removed by a command other than purge page");

    a_entry_write_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ent_we |-> ((r_state == S_WRITE) && (r_req.func == FUNC_INSERT)))
        else $error("entry memory written outside an insert");
`endif

endmodule
`default_nettype wire

@@ tb/tb_two_way_page_table_cache_unit.sv @@
`default_nettype none
module tb_two_way_page_table_cache_unit;
    import tptc_pkg::*;

    localparam int unsigned SETS          = 1 << 10;
    localparam int unsigned RANDOM_ITEMS  = 400;
    localparam int unsigned WIDE_BUDGET   = 40;
    localparam int unsigned CYCLE_LIMIT   = 500000;

    typedef struct {
        t_req req;
        bit   typed;
        t_res want;
    } t_stim_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    t_req                i_req = '0;
    logic                o_done;
    t_res                o_res;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [RTAG_W-1:0]   i_cfg_data = '0;

    // Shadow of the tag store and the victim selector
    logic [TAG_W-1:0]    way0_tags [SETS];
    logic [TAG_W-1:0]    way1_tags [SETS];
    logic                victim_toggle = 1'b0;
    logic [RTAG_W-1:0]   resid_mask = '0;

    t_res                outcomes_due [$];
    t_stim_row           directed_rows [$];

    int unsigned cycle_count = 0;
    int unsigned mismatches = 0;
    int unsigned results_checked = 0;
    int unsigned requests_sent = 0;
    int unsigned n_inserts = 0;
    int unsigned n_page_purges = 0;
    int unsigned n_purge_hits = 0;
    int unsigned n_wide_purges = 0;
    int unsigned n_evictions = 0;
    int unsigned burst_left = 0;

    logic [ASID_W-1:0]    asid_pool [4];
    logic [OUT_IDX_W-1:0] set_pool [4];

    two_way_page_table_cache_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_done      (o_done),
        .o_res       (o_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, outcomes_due.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // Compute the outcome of one accepted request and advance the shadow state
    function automatic t_res cache_outcome(t_req req);
        t_res                  res;
        logic [OUT_IDX_W-1:0]  set;
        logic [TAG_W-1:0]      tag;
        logic [WORD_W-1:0]     rtag;
        res  = '0;
        set  = req.vpn[OUT_IDX_W-1:0] ^ req.asid;
        tag  = {req.vpn[OUT_IDX_W+TAG_PG_W-1:OUT_IDX_W], req.asid};
        rtag = WORD_W'(req.vpn[VPN_W-1:VPN_W-RTAG_W] & resid_mask) << RTAG_SHIFT;
        case (req.func)
            FUNC_INSERT: begin
                n_inserts++;
                if (way0_tags[set] == tag) begin
                    res.way_used = 1'b0;
                end else if (way1_tags[set] == tag) begin
                    res.way_used = 1'b1;
                end else if (way0_tags[set] == '0) begin
                    res.way_used = 1'b0;
                end else if (way1_tags[set] == '0) begin
                    res.way_used = 1'b1;
                end else begin
                    // both ways taken: evict by the toggle, then flip it
                    res.way_used = ~victim_toggle;
                    victim_toggle = ~victim_toggle;
                    n_evictions++;
                end
                if (res.way_used) way1_tags[set] = tag;
                else way0_tags[set] = tag;
                res.stored_word = (req.pte_word & ~(WORD_W'(4'hf) << RTAG_SHIFT)) | rtag;
                res.wrote_entry = 1'b1;
                res.set_index   = set;
                res.tag_value   = tag;
                res.purge_kind  = KIND_NONE;
                res.purge_asid  = req.asid;
                res.purge_vpn   = req.vpn;
                res.target_out  = req.insert_target;
            end
            FUNC_PURGE_PAGE: begin
                n_page_purges++;
                if (way0_tags[set] == tag) begin
                    way0_tags[set] = '0;
                    res.removed_entry = 1'b1;
                end else if (way1_tags[set] == tag) begin
                    way1_tags[set] = '0;
                    res.way_used = 1'b1;
                    res.removed_entry = 1'b1;
                end
                if (res.removed_entry) n_purge_hits++;
                res.set_index  = set;
                res.tag_value  = tag;
                res.purge_kind = KIND_PAGE;
                res.purge_asid = req.asid;
                res.purge_vpn  = req.vpn;
            end
            default: begin
                // purge all and purge by asid both free every tag
                n_wide_purges++;
                foreach (way0_tags[i]) begin
                    way0_tags[i] = '0;
                    way1_tags[i] = '0;
                end
                if (req.func == FUNC_PURGE_ASID) begin
                    res.purge_kind = KIND_ASID;
                    res.purge_asid = req.asid;
                end else begin
                    res.purge_kind = KIND_ALL;
                end
            end
        endcase
        return res;
    endfunction

    function automatic string field_diffs(t_res e, t_res a);
        string s;
        s = "";
        if (e.set_index != a.set_index) s = {s, " set_index"};
        if (e.way_used != a.way_used) s = {s, " way_used"};
        if (e.wrote_entry != a.wrote_entry) s = {s, " wrote_entry"};
        if (e.removed_entry != a.removed_entry) s = {s, " removed_entry"};
        if (e.stored_word != a.stored_word) s = {s, " stored_word"};
        if (e.tag_value != a.tag_value) s = {s, " tag_value"};
        if (e.purge_kind != a.purge_kind) s = {s, " purge_kind"};
        if (e.purge_asid != a.purge_asid) s = {s, " purge_asid"};
        if (e.purge_vpn != a.purge_vpn) s = {s, " purge_vpn"};
        if (e.target_out != a.target_out) s = {s, " target_out"};
        return s;
    endfunction

    function automatic t_req mk_req(t_func f, logic [ASID_W-1:0] asid,
                                    logic [VPN_W-1:0] vpn, logic [WORD_W-1:0] pte,
                                    logic tgt);
        t_req r;
        r.func = f;
        r.asid = asid;
        r.vpn = vpn;
        r.pte_word = pte;
        r.insert_target = tgt;
        return r;
    endfunction

    function automatic t_res mk_res(logic [OUT_IDX_W-1:0] set, logic way, logic wrote,
                                    logic removed, logic [WORD_W-1:0] stored,
                                    logic [TAG_W-1:0] tag, logic [1:0] kind,
                                    logic [ASID_W-1:0] asid, logic [VPN_W-1:0] vpn,
                                    logic tgt);
        t_res r;
        r.set_index = set;
        r.way_used = way;
        r.wrote_entry = wrote;
        r.removed_entry = removed;
        r.stored_word = stored;
        r.tag_value = tag;
        r.purge_kind = kind;
        r.purge_asid = asid;
        r.purge_vpn = vpn;
        r.target_out = tgt;
        return r;
    endfunction

    // Mostly requests that crowd a few sets with a few tags, some pure noise
    function automatic t_req random_request();
        t_req                  r;
        logic [ASID_W-1:0]     asid;
        logic [TAG_PG_W-1:0]   page;
        int unsigned           pick;
        r = '0;
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
            r.func = t_func'($urandom_range(0, 1));
            r.asid = ASID_W'($urandom);
            r.vpn = VPN_W'($urandom);
        end else begin
            asid = asid_pool[$urandom_range(0, 3)];
            page = TAG_PG_W'($urandom_range(0, 3));
            r.asid = asid;
            r.vpn = {RTAG_W'($urandom), page, set_pool[$urandom_range(0, 3)] ^ asid};
            r.func = (pick < 85) ? FUNC_INSERT : FUNC_PURGE_PAGE;
        end
        // wide purges are slow, so keep them rare and bounded
        if ($urandom_range(0, 99) < 3 && n_wide_purges < WIDE_BUDGET)
            r.func = $urandom_range(0, 1) ? FUNC_PURGE_ALL : FUNC_PURGE_ASID;
        r.pte_word = $urandom;
        r.insert_target = 1'($urandom);
        return r;
    endfunction

    // Present one request and hold it until busy is seen low
    task automatic send_request(input t_req req, input bit typed, input t_res want);
        t_res predicted;
        i_req <= req;
        if (!start) start <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predicted = cache_outcome(req);
        outcomes_due.push_back(typed ? want : predicted);
        requests_sent++;
    endtask

    task automatic pause(input int unsigned cycles);
        if (cycles > 0) begin
            if (start) start <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // Drop start and wait until every result is in and the block is idle
    task automatic settle_block();
        if (start) start <= 1'b0;
        @(posedge i_clk);
        while (outcomes_due.size() != 0 || busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_resid_mask(input logic [RTAG_W-1:0] value);
        settle_block();
        i_cfg_data <= value;
        i_cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        resid_mask = value;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic random_phase(input int unsigned count);
        repeat (count) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                pause(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
            end
            burst_left--;
            send_request(random_request(), 1'b0, '0);
        end
    endtask

    // Check each result against the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_res  want;
        string diffs;
        if (i_rst_n && o_done) begin
            if (outcomes_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", o_res);
            end else begin
                want = outcomes_due.pop_front();
                results_checked++;
                diffs = field_diffs(want, o_res);
                if (diffs != "") begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch in%s\n  expected %p\n  actual   %p",
                                 diffs, want, o_res);
                end
            end
        end
    end

    initial begin
        foreach (way0_tags[i]) begin
            way0_tags[i] = '0;
            way1_tags[i] = '0;
        end
        asid_pool = '{10'h000, 10'h001, 10'h3ff, ASID_W'($urandom)};
        set_pool = '{10'h000, 10'h001, 10'h155, 10'h3ff};

        // extremes, every function, eviction, update, misses and the zero tag
        directed_rows.push_back('{mk_req(FUNC_INSERT, 10'h000, 20'h00000, 32'h0000_0000, 1'b0),
            1'b1, mk_res(10'h000, 1'b0, 1'b1, 1'b0, 32'h0000_0000, 16'h0000, KIND_NONE,
                         10'h000, 20'h00000, 1'b0)});
        directed_rows.push_back('{mk_req(FUNC_INSERT, 10'h3ff, 20'hfffff, 32'hffff_ffff, 1'b1),
            1'b1, mk_res(10'h000, 1'b0, 1'b1, 1'b0, 32'hffff_fff0, 16'hffff, KIND_NONE,
                         10'h3ff, 20'hfffff, 1'b1)});
        directed_rows.push_back('{mk_req(FUNC_INSERT, 10'h001, 20'h00401, 32'h1234_5678, 1'b0),
            1'b0, '0});
        directed_rows.push_back('{mk_req(FUNC_INSERT, 10'h002, 20'h00802, 32'h9abc_def0, 1'b1),
            1'b0, '0});
        directed_rows.push_back('{mk_req(FUNC_INSERT, 10'h003, 20'h00c03, 32'h0f0f_0f0f, 1'b0),
            1'b0, '0});
        directed_rows.push_back('{mk_req(FUNC_INSERT, 10'h002, 20'h00802, 32'h1111_1111, 1'b1),
            1'b0, '0});
        directed_rows.push_back('{mk_req(FUNC_PURGE_PAGE, 10'h002, 20'h00802, 32'h0, 1'b0),
            1'b0, '0});
        directed_rows.push_back('{mk_req(FUNC_PURGE_PAGE, 10'h005, 20'h12345, 32'hdead_beef, 1'b1),
            1'b1, mk_res(10'h340, 1'b0, 1'b0, 1'b0, 32'h0, 16'h2005, KIND_PAGE,
                         10'h005, 20'h12345, 1'b0)});
        directed_rows.push_back('{mk_req(FUNC_PURGE_ASID, 10'h2aa, 20'h55555, 32'haaaa_aaaa, 1'b1),
            1'b1, mk_res(10'h000, 1'b0, 1'b0, 1'b0, 32'h0, 16'h0000, KIND_ASID,
                         10'h2aa, 20'h00000, 1'b0)});
        directed_rows.push_back('{mk_req(FUNC_INSERT, 10'h003, 20'h00c03, 32'h0f0f_0f0f, 1'b0),
            1'b0, '0});
        directed_rows.push_back('{mk_req(FUNC_PURGE_ALL, 10'h155, 20'haaaaa, 32'h5555_5555, 1'b1),
            1'b1, mk_res(10'h000, 1'b0, 1'b0, 1'b0, 32'h0, 16'h0000, KIND_ALL,
                         10'h000, 20'h00000, 1'b0)});
        directed_rows.push_back('{mk_req(FUNC_INSERT, 10'h155, 20'haaaaa, 32'h5555_5555, 1'b0),
            1'b0, '0});
        directed_rows.push_back('{mk_req(FUNC_PURGE_PAGE, 10'h155, 20'haaaaa, 32'h0, 1'b0),
            1'b0, '0});
        directed_rows.push_back('{mk_req(FUNC_PURGE_PAGE, 10'h000, 20'h00000, 32'hffff_ffff, 1'b1),
            1'b0, '0});

        // hold reset, then release it once
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);

        // random phases across residual tag mask settings, extremes first
        write_resid_mask(4'hf);
        random_phase(RANDOM_ITEMS);
        write_resid_mask(4'h0);
        random_phase(RANDOM_ITEMS);
        write_resid_mask(RTAG_W'($urandom_range(1, 14)));
        random_phase(RANDOM_ITEMS);
        write_resid_mask(4'ha);
        random_phase(RANDOM_ITEMS);

        settle_block();
        repeat (8) @(posedge i_clk);

        $display("sent %0d requests: %0d inserts (%0d evictions), %0d page purges (%0d hits),",
                 requests_sent, n_inserts, n_evictions, n_page_purges, n_purge_hits);
        $display("%0d full purges, %0d results checked, %0d mismatches",
                 n_wide_purges, results_checked, mismatches);
        if (mismatches == 0 && outcomes_due.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
`default_nettype wire
